/* hdl/lpd_pkg.sv */
package lpd_pkg;

  localparam int unsigned LEN_W     = 64;
  localparam int unsigned PLEN_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_PREFIX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT       = 3'd5;

  localparam logic [PLEN_W-1:0] PREFIX_LENGTH_RST = 4'd4;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_FRAME_LIMIT = 2'd0;
  localparam logic [1:0] ERR_PAYLOAD_BUF = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW    = 2'd2;
  localparam logic [1:0] ERR_FRAME_BUF   = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [1:0]        code;
  } result_t;

endpackage

/* hdl/lpd_outq.sv */
module lpd_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::result_t push_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output lpd_pkg::result_t out_data_o,
  output logic             full_o
);

  logic             v0_q, v0_d, v1_q, v1_d;
  lpd_pkg::result_t d0_q, d0_d, d1_q, d1_d;
  logic             pop;

  assign pop = v0_q && !out_stall_i;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    if (pop) begin
      if (v1_q) begin
        d0_d = d1_q;
        v1_d = 1'b0;
      end else begin
        v0_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        d0_d = push_data_i;
      end else begin
        v1_d = 1'b1;
        d1_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

  assign out_valid_o = v0_q;
  assign out_data_o  = d0_q;
  assign full_o      = v1_q;

endmodule

/* hdl/length_prefix_deframer.sv */
// length-prefixed message deframer
// input channel: one raw stream byte per item (in_valid_i / in_stall_o / in_byte_i)
// output channel: one result per item (out_valid_o / out_stall_i), carrying kind_o,
// out_byte_o, last_o and error_code_o; kind is message byte, empty message or error
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; the user must
// write only while no message is in flight, as the block does not enforce it
// a taken payload byte enters the output queue and shows once earlier results leave
// throughput: payload bytes pass at one per cycle while the output queue has room;
// prefix bytes are gathered first, then the length checks run, and include-prefix
// mode replays the stored prefix bytes from the prefix registers, one per cycle
// while the queue has room; a two-entry output queue lets an item be taken while
// one result waits; in the payload state in_stall_o rises when both entries are full
// and nothing is lost while the receiver stalls; a failed length check emits one
// error result and the block then stalls its input until reset
// reset: config returns to its defaults (4-byte big-endian prefix, no limits), the
// output queue empties and the block waits for the first prefix byte
module length_prefix_deframer #(
  parameter int unsigned MaxPrefixBytes = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lpd_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lpd_pkg::BYTE_W-1:0]         in_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [lpd_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               last_o,
  output logic [1:0]                         error_code_o
);

  localparam int unsigned CntW = $clog2(MaxPrefixBytes + 1);
  localparam int unsigned IdxW = (MaxPrefixBytes > 1) ? $clog2(MaxPrefixBytes) : 1;
  localparam int unsigned LenW = lpd_pkg::LEN_W;

  typedef enum logic [4:0] {
    ST_PREFIX  = 5'b00001,
    ST_CHECK   = 5'b00010,
    ST_REPLAY  = 5'b00100,
    ST_PAYLOAD = 5'b01000,
    ST_HALT    = 5'b10000
  } state_e;

  logic [lpd_pkg::PLEN_W-1:0] prefix_length_q;
  logic                       little_endian_q;
  logic                       include_prefix_q;
  logic                       frame_limit_enable_q;
  logic [LenW-1:0]            frame_limit_q;
  logic [LenW-1:0]            buffer_limit_q;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d, cnt_inc;
  logic [IdxW-1:0]            ridx_q, ridx_d;
  logic [LenW-1:0]            rem_q, rem_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [LenW-1:0]            acc_q, acc_d, le_val;
  logic [lpd_pkg::PLEN_W-1:0] n_q, n_eff;
  logic [MaxPrefixBytes-1:0][lpd_pkg::BYTE_W-1:0] store_q, store_nx;

  logic             in_acc, pfx_acc, done, q_full, len_zero, rlast, rem_one;
  logic             e0, e1, e2, e3;
  logic [LenW:0]    sum;
  logic             push;
  lpd_pkg::result_t push_data, out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_length_q      <= lpd_pkg::PREFIX_LENGTH_RST;
      little_endian_q      <= 1'b0;
      include_prefix_q     <= 1'b0;
      frame_limit_enable_q <= 1'b0;
      frame_limit_q        <= '0;
      buffer_limit_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpd_pkg::CFG_PREFIX_LENGTH:      prefix_length_q <= cfg_data_i[lpd_pkg::PLEN_W-1:0];
        lpd_pkg::CFG_LITTLE_ENDIAN:      little_endian_q <= cfg_data_i[0];
        lpd_pkg::CFG_INCLUDE_PREFIX:     include_prefix_q <= cfg_data_i[0];
        lpd_pkg::CFG_FRAME_LIMIT_ENABLE: frame_limit_enable_q <= cfg_data_i[0];
        lpd_pkg::CFG_FRAME_LIMIT:        frame_limit_q <= cfg_data_i;
        lpd_pkg::CFG_BUFFER_LIMIT:       buffer_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective prefix size, clamped to 1..MaxPrefixBytes
  always_comb begin
    if (prefix_length_q == '0) begin
      n_eff = lpd_pkg::PLEN_W'(1);
    end else if (prefix_length_q > lpd_pkg::PLEN_W'(MaxPrefixBytes)) begin
      n_eff = lpd_pkg::PLEN_W'(MaxPrefixBytes);
    end else begin
      n_eff = prefix_length_q;
    end
  end

  assign in_stall_o = !((state_q == ST_PREFIX) || ((state_q == ST_PAYLOAD) && !q_full));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pfx_acc    = in_acc && (state_q == ST_PREFIX);
  assign cnt_inc    = cnt_q + CntW'(1);
  assign done       = lpd_pkg::PLEN_W'(cnt_inc) >= n_eff;

  // big-endian value shifts in, little-endian value is the byte lanes themselves
  always_comb begin
    store_nx = store_q;
    store_nx[cnt_q[IdxW-1:0]] = in_byte_i;
    acc_d = (cnt_q == '0) ? LenW'(in_byte_i) : {acc_q[LenW-9:0], in_byte_i};
    le_val = '0;
    for (int j = 0; j < MaxPrefixBytes; j++) begin
      if (lpd_pkg::PLEN_W'(j) < n_eff) begin
        le_val[8*j +: 8] = store_nx[j];
      end
    end
    len_d = little_endian_q ? le_val : acc_d;
  end

  always_ff @(posedge clk_i) begin
    if (pfx_acc) begin
      store_q[cnt_q[IdxW-1:0]] <= in_byte_i;
      acc_q <= acc_d;
      if (done) begin
        len_q <= len_d;
        n_q   <= n_eff;
      end
    end
    rem_q <= rem_d;
  end

  // length checks, first failing one wins
  assign sum      = {1'b0, len_q} + (LenW + 1)'(n_q);
  assign e0       = frame_limit_enable_q && (len_q > frame_limit_q);
  assign e1       = (buffer_limit_q != '0) && (len_q > buffer_limit_q);
  assign e2       = sum[LenW];
  assign e3       = (buffer_limit_q != '0) && (sum[LenW-1:0] > buffer_limit_q);
  assign len_zero = (len_q == '0);
  assign rlast    = (lpd_pkg::PLEN_W'(ridx_q) + lpd_pkg::PLEN_W'(1)) == n_q;
  assign rem_one  = (rem_q == LenW'(1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    rem_d     = rem_q;
    push      = 1'b0;
    push_data = '{kind: lpd_pkg::KIND_BYTE, data: '0, last: 1'b0, code: '0};
    case (state_q)
      ST_PREFIX: begin
        if (pfx_acc) begin
          if (done) begin
            cnt_d   = '0;
            state_d = ST_CHECK;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_CHECK: begin
        if (!q_full) begin
          if (e0 || e1 || e2 || e3) begin
            push           = 1'b1;
            push_data.kind = lpd_pkg::KIND_ERROR;
            if (e0) begin
              push_data.code = lpd_pkg::ERR_FRAME_LIMIT;
            end else if (e1) begin
              push_data.code = lpd_pkg::ERR_PAYLOAD_BUF;
            end else if (e2) begin
              push_data.code = lpd_pkg::ERR_OVERFLOW;
            end else begin
              push_data.code = lpd_pkg::ERR_FRAME_BUF;
            end
            state_d = ST_HALT;
          end else if (include_prefix_q) begin
            ridx_d  = '0;
            state_d = ST_REPLAY;
          end else if (len_zero) begin
            push           = 1'b1;
            push_data.kind = lpd_pkg::KIND_EMPTY;
            push_data.last = 1'b1;
            state_d        = ST_PREFIX;
          end else begin
            rem_d   = len_q;
            state_d = ST_PAYLOAD;
          end
        end
      end
      ST_REPLAY: begin
        if (!q_full) begin
          push           = 1'b1;
          push_data.data = store_q[ridx_q];
          push_data.last = rlast && len_zero;
          ridx_d         = ridx_q + IdxW'(1);
          if (rlast) begin
            if (len_zero) begin
              state_d = ST_PREFIX;
            end else begin
              rem_d   = len_q;
              state_d = ST_PAYLOAD;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          push           = 1'b1;
          push_data.data = in_byte_i;
          push_data.last = rem_one;
          rem_d          = rem_q - LenW'(1);
          if (rem_one) begin
            state_d = ST_PREFIX;
          end
        end
      end
      ST_HALT: ;
      default: state_d = ST_HALT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREFIX;
      cnt_q   <= '0;
      ridx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ridx_q  <= ridx_d;
    end
  end

  lpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (q_full)
  );

  assign kind_o       = out_data.kind;
  assign out_byte_o   = out_data.data;
  assign last_o       = out_data.last;
  assign error_code_o = out_data.code;

endmodule

/* hdl/lpd_checker.sv */
module lpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic [1:0] error_code_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_byte_o)
      && $stable(last_o) && $stable(error_code_o))
  else $error("stalled result changed");

  // error is the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == lpd_pkg::KIND_ERROR) |=> !out_valid_o)
  else $error("result after framing error");

  // halted after error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lpd_pkg::KIND_ERROR) |=> in_stall_o)
  else $error("input taken after framing error");

  // only message bytes carry data, only errors carry a code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != lpd_pkg::KIND_BYTE) |->
      (out_byte_o == 8'd0) && (last_o == (kind_o == lpd_pkg::KIND_EMPTY))
      && ((kind_o == lpd_pkg::KIND_ERROR) || (error_code_o == 2'd0)))
  else $error("bad non-byte result fields");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .out_byte_o   (out_byte_o),
  .last_o       (last_o),
  .error_code_o (error_code_o)
);

/* verif/deframe_checker.sv */
module deframe_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpd_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [lpd_pkg::BYTE_W-1:0]    in_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    kind_i,
  input  logic [lpd_pkg::BYTE_W-1:0]    out_byte_i,
  input  logic                          last_i,
  input  logic [1:0]                    error_code_i,
  output int unsigned                   fails_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_GATHER  = 3'b001,
    ST_PASSING = 3'b010,
    ST_HALTED  = 3'b100
  } deframe_state_e;

  deframe_state_e state;
  logic [3:0]     gathered;
  logic [63:0]    left;
  logic [7:0]     pfx_store [8];

  logic [3:0]     cfg_plen;
  logic           cfg_le;
  logic           cfg_inc;
  logic           cfg_fle;
  logic [63:0]    cfg_flim;
  logic [63:0]    cfg_blim;

  lpd_pkg::result_t framed_out_q [$];
  int unsigned      fails;

  function automatic lpd_pkg::result_t mk_result(input logic [1:0] kind,
                                                 input logic [7:0] data,
                                                 input logic last, input logic [1:0] code);
    lpd_pkg::result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.code = code;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic consume_stream_byte(input logic [7:0] b);
    int unsigned n;
    int          i;
    int          idx;
    logic [63:0] v;
    logic [1:0]  code;
    logic        rejected;
    if (state == ST_PASSING) begin
      left = left - 64'd1;
      framed_out_q.push_back(mk_result(lpd_pkg::KIND_BYTE, b, left == 64'd0, '0));
      if (left == 64'd0) state = ST_GATHER;
    end else if (state == ST_GATHER) begin
      pfx_store[gathered[2:0]] = b;
      gathered = gathered + 4'd1;
      n = (cfg_plen == 4'd0) ? 1 : (cfg_plen > 4'd8) ? 8 : cfg_plen;
      if (gathered >= n) begin
        gathered = '0;
        v = '0;
        for (i = 0; i < n; i++) begin
          idx = cfg_le ? n - 1 - i : i;
          v = {v[55:0], pfx_store[idx]};
        end
        rejected = 1'b1;
        code = '0;
        // checks in priority order, first failure wins
        if (cfg_fle && v > cfg_flim) code = lpd_pkg::ERR_FRAME_LIMIT;
        else if (cfg_blim != 64'd0 && v > cfg_blim) code = lpd_pkg::ERR_PAYLOAD_BUF;
        else if (64'(n) > ~v) code = lpd_pkg::ERR_OVERFLOW;
        else if (cfg_blim != 64'd0 && v + 64'(n) > cfg_blim) code = lpd_pkg::ERR_FRAME_BUF;
        else rejected = 1'b0;
        if (rejected) begin
          framed_out_q.push_back(mk_result(lpd_pkg::KIND_ERROR, '0, 1'b0, code));
          state = ST_HALTED;
        end else begin
          if (cfg_inc) begin
            for (i = 0; i < n; i++)
              framed_out_q.push_back(mk_result(lpd_pkg::KIND_BYTE, pfx_store[i],
                                               i == n - 1 && v == 64'd0, '0));
          end else if (v == 64'd0) begin
            framed_out_q.push_back(mk_result(lpd_pkg::KIND_EMPTY, '0, 1'b1, '0));
          end
          if (v != 64'd0) begin
            left = v;
            state = ST_PASSING;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lpd_pkg::result_t want;
    if (!rst_ni) begin
      state = ST_GATHER;
      gathered = '0;
      left = '0;
      cfg_plen = lpd_pkg::PREFIX_LENGTH_RST;
      cfg_le = 1'b0;
      cfg_inc = 1'b0;
      cfg_fle = 1'b0;
      cfg_flim = '0;
      cfg_blim = '0;
      framed_out_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (framed_out_q.size() == 0) begin
          $error("result with nothing awaited: kind %0d byte %0h last %0b code %0d",
                 kind_i, out_byte_i, last_i, error_code_i);
          fails++;
        end else begin
          want = framed_out_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind_i));
          check_field("out_byte", want.data, out_byte_i);
          check_field("last", 8'(want.last), 8'(last_i));
          check_field("error_code", 8'(want.code), 8'(error_code_i));
        end
      end
      if (in_valid_i && !in_stall_i) consume_stream_byte(in_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lpd_pkg::CFG_PREFIX_LENGTH:      cfg_plen = cfg_data_i[3:0];
          lpd_pkg::CFG_LITTLE_ENDIAN:      cfg_le = cfg_data_i[0];
          lpd_pkg::CFG_INCLUDE_PREFIX:     cfg_inc = cfg_data_i[0];
          lpd_pkg::CFG_FRAME_LIMIT_ENABLE: cfg_fle = cfg_data_i[0];
          lpd_pkg::CFG_FRAME_LIMIT:        cfg_flim = cfg_data_i;
          lpd_pkg::CFG_BUFFER_LIMIT:       cfg_blim = cfg_data_i;
          default: ;
        endcase
      end
    end
    fails_o <= fails;
    pending_o <= framed_out_q.size();
  end

endmodule

/* verif/tb_length_prefix_deframer.sv */
module tb_length_prefix_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 150;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lpd_pkg::LEN_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [lpd_pkg::BYTE_W-1:0]    in_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    kind;
  logic [lpd_pkg::BYTE_W-1:0]    out_byte;
  logic                          last;
  logic [1:0]                    err_code;
  int unsigned                   fails;
  int unsigned                   pending;
  int unsigned                   idle_cycles;

  // local copy of the settings used to build frames, then input and result pacing controls
  int          pfx_n;
  logic        le_r;
  logic        burst;
  int          in_calm;
  logic        long_hold;

  length_prefix_deframer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .out_byte_o  (out_byte),
    .last_o      (last),
    .error_code_o(err_code)
  );

  deframe_checker frame_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .out_byte_i  (out_byte),
    .last_i      (last),
    .error_code_i(err_code),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pfx_len_for(input logic [3:0] plen);
    return (plen == 4'd0) ? 1 : (plen > 4'd8) ? 8 : int'(plen);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (burst || in_calm > 0) ? 0 : $urandom_range(0, 13);
    if (in_calm > 0) in_calm--;
    else if ($urandom_range(0, 9) == 0) in_calm = $urandom_range(8, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic send_prefix(input logic [63:0] len);
    int i;
    for (i = 0; i < pfx_n; i++)
      send_byte(le_r ? 8'(len >> (8 * i)) : 8'(len >> (8 * (pfx_n - 1 - i))));
  endtask

  task automatic send_frame(input logic [63:0] len, input int fill);
    int i;
    send_prefix(len);
    for (i = 0; i < int'(len); i++)
      send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [3:0] plen, input logic le, input logic inc,
                                input logic fle, input logic [63:0] flim,
                                input logic [63:0] blim);
    pfx_n = pfx_len_for(plen);
    le_r = le;
    cfg_we <= 1'b1;
    cfg_idx <= lpd_pkg::CFG_PREFIX_LENGTH;
    cfg_data <= 64'(plen);
    @(posedge clk);
    cfg_idx <= lpd_pkg::CFG_LITTLE_ENDIAN;
    cfg_data <= 64'(le);
    @(posedge clk);
    cfg_idx <= lpd_pkg::CFG_INCLUDE_PREFIX;
    cfg_data <= 64'(inc);
    @(posedge clk);
    cfg_idx <= lpd_pkg::CFG_FRAME_LIMIT_ENABLE;
    cfg_data <= 64'(fle);
    @(posedge clk);
    cfg_idx <= lpd_pkg::CFG_FRAME_LIMIT;
    cfg_data <= flim;
    @(posedge clk);
    cfg_idx <= lpd_pkg::CFG_BUFFER_LIMIT;
    cfg_data <= blim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side
  initial begin
    int   w;
    int   calm;
    logic hold_done;
    out_stall <= 1'b0;
    calm = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        w = HOLD_CYCLES;
      end else if (calm > 0) begin
        w = 0;
        calm--;
      end else begin
        w = $urandom_range(0, 13);
        if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 24);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          ph;
    int          sent;
    int          len;
    int          max_len;
    logic [3:0]  plen;
    logic [63:0] lim;
    logic [1:0]  target;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= lpd_pkg::CFG_PREFIX_LENGTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_byte <= '0;
    pfx_n = pfx_len_for(lpd_pkg::PREFIX_LENGTH_RST);
    le_r = 1'b0;
    burst = 1'b0;
    in_calm = 0;
    long_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: empty message, then all-ones payload
    send_frame(64'd0, -1);
    send_frame(64'd2, 8'hff);
    wait_drained();
    // prefix length zero acts as one, prefix replay incl. zero-length frame
    apply_settings(4'd0, 1'b1, 1'b1, 1'b0, 64'd0, 64'd0);
    send_frame(64'd0, -1);
    send_frame(64'd1, 8'h00);
    wait_drained();
    // oversized prefix length, limits exactly at the boundary
    apply_settings(4'd15, 1'b0, 1'b1, 1'b1, 64'd3, 64'd11);
    send_frame(64'd3, -1);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      plen = 4'($urandom_range(0, 15));
      max_len = 12;
      case (ph % 4)
        0: apply_settings(plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                          {$urandom, $urandom}, 64'd0);
        1: begin
          max_len = $urandom_range(1, 12);
          apply_settings(plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                         64'(max_len), 64'(max_len + pfx_len_for(plen)));
        end
        2: apply_settings(plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                          '1, '1);
        default: begin
          max_len = 0;
          apply_settings(plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                         64'd0, 64'd0);
        end
      endcase
      burst = (ph == 1) || ($urandom_range(0, 3) == 0);
      if (ph == 1) long_hold = 1'b1;
      sent = 0;
      while (sent < ((ph == 1) ? 28 : 6)) begin
        len = $urandom_range(0, max_len);
        send_frame(64'(len), -1);
        sent += pfx_n + len;
      end
      burst = 1'b0;
      wait_drained();
    end

    // a rejected length halts the block, so only one per run
    target = 2'($urandom_range(0, 3));
    case (target)
      lpd_pkg::ERR_FRAME_LIMIT: begin
        lim = 64'($urandom_range(0, 99));
        apply_settings(4'd2, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                       lim, 64'd0);
        send_prefix(lim + 64'd1);
      end
      lpd_pkg::ERR_PAYLOAD_BUF: begin
        lim = 64'($urandom_range(1, 99));
        apply_settings(4'd2, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), '1, lim);
        send_prefix(lim + 64'd1);
      end
      lpd_pkg::ERR_OVERFLOW: begin
        apply_settings(4'd8, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), '1, 64'd0);
        send_prefix('1);
      end
      default: begin
        lim = 64'($urandom_range(3, 99));
        apply_settings(4'd3, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                       64'd0, lim);
        send_prefix(lim - 64'($urandom_range(0, 2)));
      end
    endcase
    wait_drained();
    repeat (8) @(posedge clk);

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lpd_pkg.sv
hdl/lpd_outq.sv
hdl/length_prefix_deframer.sv
hdl/lpd_checker.sv
verif/deframe_checker.sv
verif/tb_length_prefix_deframer.sv
